// ===== rtl/core/clba_pkg.sv =====
// Shared constants, types and helpers of the cell-to-lattice box average.
`default_nettype none

package clba_pkg;

   localparam int MAX_DIM    = 63;
   localparam int LINE_LEN   = MAX_DIM + 1;
   localparam int COORD_W    = $clog2(LINE_LEN);
   localparam int COL_W      = COORD_W - 1;
   localparam int BANK_AW    = COORD_W + COL_W;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   localparam int DIM_W     = 6;
   localparam int DATA_W    = 16;
   localparam int SUM4_W    = DATA_W + 2;
   localparam int SUM8_W    = DATA_W + 3;
   localparam int SHIFT_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Z = CSR_IDX_W'(2);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1);

   typedef struct packed {
      logic               vx0;
      logic               vx1;
      logic               vy0;
      logic               vy1;
      logic               vz0;
      logic               vz1;
      logic [SHIFT_W-1:0] shift;
      logic               last;
   } item_ctl_type;

   typedef struct packed {
      logic               rd_en;
      logic [COORD_W-1:0] crs_rd_addr;
      logic               crs_we;
      logic [COORD_W-1:0] crs_wr_addr;
      logic [DATA_W-1:0]  crs_wr_data;
      logic               x_odd;
      logic [COL_W-1:0]   col_even;
      logic [COL_W-1:0]   col_odd;
      logic [COORD_W-1:0] row_here;
      logic [COORD_W-1:0] row_up;
      logic               pp_we;
      logic               pp_wr_odd;
      logic [BANK_AW-1:0] pp_wr_addr;
   } mem_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] row_here;
      logic [DATA_W-1:0] row_left;
      logic [DATA_W-1:0] pp_here;
      logic [DATA_W-1:0] pp_left;
      logic [DATA_W-1:0] pp_here_up;
      logic [DATA_W-1:0] pp_left_up;
   } mem_rsp_type;

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [COORD_W-1:0] result;
      if (int'(d) > MAX_DIM) begin
         result = COORD_W'(MAX_DIM);
      end else begin
         result = COORD_W'(d);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cell_to_lattice_box_average_core.sv =====
// Top level of the cell-to-lattice box average.
`default_nettype none

// Takes one beat per lattice point of a (dim_x+1) x (dim_y+1) x (dim_z+1)
// lattice in raster order, x fastest, and returns one beat per point holding
// the truncated mean of the up to eight grid cells that touch it, with tlast
// on the final point of the volume. One beat is accepted every clock cycle
// when the result side keeps up; a result passes s1, s2 and the output register
// after its beat is accepted. Every store access of a beat, the reads of the
// row store and of both previous-plane banks and the delayed write-backs,
// happens at the edge that accepts it, so no store limits the rate below one
// beat per cycle. The stores need no clearing pass after reset; dimension
// registers should be written between volumes, since a volume started under
// other dimensions reads store entries that may not have been written for it.
module cell_to_lattice_box_average_core (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            req_tvalid,
   output logic                                  req_tready,
   // [15:0] cell_density
   input  wire  logic [clba_pkg::DATA_W-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  wire  logic                            rsp_tready,
   // [15:0] sample_density
   output logic [clba_pkg::DATA_W-1:0]           rsp_tdata,
   output logic                                  rsp_tlast,
   input  wire  logic                            csr_we,
   input  wire  logic [clba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [clba_pkg::DIM_W-1:0]      csr_wdata
);
   import clba_pkg::*;

   item_ctl_type      item_ctl;
   mem_req_type       mem_req;
   mem_rsp_type       mem_rsp;
   logic [DATA_W-1:0] prev_cell;
   logic              accept;

   assign accept = req_tvalid & req_tready;

   clba_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .cell_density (req_tdata),
      .item_ctl     (item_ctl),
      .mem_req      (mem_req),
      .prev_cell    (prev_cell)
   );

   clba_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   clba_avg u_avg (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .cell_density (req_tdata),
      .prev_cell    (prev_cell),
      .item_ctl     (item_ctl),
      .mem_rsp      (mem_rsp),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/clba_seq.sv =====
// Dimension registers, lattice position tracking and store address generation.
`default_nettype none

module clba_seq (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            csr_we,
   input  wire  logic [clba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [clba_pkg::DIM_W-1:0]      csr_wdata,
   input  wire  logic                            accept,
   input  wire  logic [clba_pkg::DATA_W-1:0]     cell_density,
   output clba_pkg::item_ctl_type                item_ctl,
   output clba_pkg::mem_req_type                 mem_req,
   output logic [clba_pkg::DATA_W-1:0]           prev_cell
);
   import clba_pkg::*;

   logic [DIM_W-1:0]   dim_x_ff, dim_y_ff, dim_z_ff;
   logic [DIM_W-1:0]   dim_x_in, dim_y_in, dim_z_in;
   logic [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [COORD_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [DATA_W-1:0]  prev_cell_ff, prev_cell_in;

   logic [COORD_W-1:0] dx, dy, dz;
   logic [COORD_W-1:0] x, y, z, xm, ym;
   logic               end_x, end_y, end_z;
   logic               vx0, vx1, vy0, vy1, vz0, vz1;

   always_comb begin
      dx = clamp_dim(dim_x_ff);
      dy = clamp_dim(dim_y_ff);
      dz = clamp_dim(dim_z_ff);
      x  = (pos_x_ff > dx) ? '0 : pos_x_ff;
      y  = (pos_y_ff > dy) ? '0 : pos_y_ff;
      z  = (pos_z_ff > dz) ? '0 : pos_z_ff;
      xm = x - COORD_W'(1);
      ym = y - COORD_W'(1);
      end_x = (x == dx);
      end_y = (y == dy);
      end_z = (z == dz);
      vx0 = (x != '0);
      vx1 = (x < dx);
      vy0 = (y != '0);
      vy1 = (y < dy);
      vz0 = (z != '0);
      vz1 = (z < dz);
   end

   always_comb begin
      item_ctl.vx0   = vx0;
      item_ctl.vx1   = vx1;
      item_ctl.vy0   = vy0;
      item_ctl.vy1   = vy1;
      item_ctl.vz0   = vz0;
      item_ctl.vz1   = vz1;
      item_ctl.shift = {1'b0, vx0 & vx1} + {1'b0, vy0 & vy1} + {1'b0, vz0 & vz1};
      item_ctl.last  = end_x & end_y & end_z;
   end

   always_comb begin
      mem_req.rd_en       = accept;
      mem_req.crs_rd_addr = x;
      mem_req.crs_we      = accept & vx0;
      mem_req.crs_wr_addr = xm;
      mem_req.crs_wr_data = prev_cell_ff;
      mem_req.x_odd       = x[0];
      mem_req.col_even    = x[0] ? xm[COORD_W-1:1] : x[COORD_W-1:1];
      mem_req.col_odd     = x[0] ? x[COORD_W-1:1] : xm[COORD_W-1:1];
      mem_req.row_here    = y;
      mem_req.row_up      = ym;
      mem_req.pp_we       = accept & vx0 & vy0;
      mem_req.pp_wr_odd   = xm[0];
      mem_req.pp_wr_addr  = {ym, xm[COORD_W-1:1]};
   end

   assign prev_cell = prev_cell_ff;

   always_comb begin
      dim_x_in = dim_x_ff;
      dim_y_in = dim_y_ff;
      dim_z_in = dim_z_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DIM_X: dim_x_in = csr_wdata;
            REG_DIM_Y: dim_y_in = csr_wdata;
            REG_DIM_Z: dim_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      prev_cell_in = prev_cell_ff;
      if (accept) begin
         prev_cell_in = cell_density;
         pos_x_in     = x;
         pos_y_in     = y;
         pos_z_in     = z;
         if (end_x) begin
            pos_x_in = '0;
            if (end_y) begin
               pos_y_in = '0;
               pos_z_in = end_z ? '0 : z + COORD_W'(1);
            end else begin
               pos_y_in = y + COORD_W'(1);
            end
         end else begin
            pos_x_in = x + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_RESET;
         dim_y_ff <= DIM_RESET;
         dim_z_ff <= DIM_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else begin
         dim_x_ff <= dim_x_in;
         dim_y_ff <= dim_y_in;
         dim_z_ff <= dim_z_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_cell_ff <= prev_cell_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/clba_store.sv =====
// Row store and banked previous-plane store with registered read data.
`default_nettype none

module clba_store (
   input  wire  logic                clock,
   input  wire  clba_pkg::mem_req_type mem_req,
   output clba_pkg::mem_rsp_type     mem_rsp
);
   import clba_pkg::*;

   logic [DATA_W-1:0] crs_mem  [LINE_LEN];
   logic [DATA_W-1:0] even_mem [BANK_DEPTH];
   logic [DATA_W-1:0] odd_mem  [BANK_DEPTH];

   logic [DATA_W-1:0] crs_q_ff;
   logic [DATA_W-1:0] even_here_ff, even_up_ff, odd_here_ff, odd_up_ff;
   logic [DATA_W-1:0] row_left_ff, row_left_in;
   logic              x_odd_ff, x_odd_in;

   // The row-store read of the previous beat is the left neighbor of this beat.
   always_ff @(posedge clock) begin
      if (mem_req.crs_we) begin
         crs_mem[mem_req.crs_wr_addr] <= mem_req.crs_wr_data;
      end
      if (mem_req.rd_en) begin
         crs_q_ff <= crs_mem[mem_req.crs_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.pp_we && !mem_req.pp_wr_odd) begin
         even_mem[mem_req.pp_wr_addr] <= crs_q_ff;
      end
      if (mem_req.rd_en) begin
         even_here_ff <= even_mem[{mem_req.row_here, mem_req.col_even}];
         even_up_ff   <= even_mem[{mem_req.row_up, mem_req.col_even}];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.pp_we && mem_req.pp_wr_odd) begin
         odd_mem[mem_req.pp_wr_addr] <= crs_q_ff;
      end
      if (mem_req.rd_en) begin
         odd_here_ff <= odd_mem[{mem_req.row_here, mem_req.col_odd}];
         odd_up_ff   <= odd_mem[{mem_req.row_up, mem_req.col_odd}];
      end
   end

   always_comb begin
      row_left_in = mem_req.rd_en ? crs_q_ff : row_left_ff;
      x_odd_in    = mem_req.rd_en ? mem_req.x_odd : x_odd_ff;
   end

   always_ff @(posedge clock) begin
      row_left_ff <= row_left_in;
      x_odd_ff    <= x_odd_in;
   end

   always_comb begin
      mem_rsp.row_here   = crs_q_ff;
      mem_rsp.row_left   = row_left_ff;
      mem_rsp.pp_here    = x_odd_ff ? odd_here_ff : even_here_ff;
      mem_rsp.pp_left    = x_odd_ff ? even_here_ff : odd_here_ff;
      mem_rsp.pp_here_up = x_odd_ff ? odd_up_ff : even_up_ff;
      mem_rsp.pp_left_up = x_odd_ff ? even_up_ff : odd_up_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/clba_avg.sv =====
// Neighbor sum and shift pipeline with output register and flow control.
`default_nettype none

module clba_avg (
   input  wire  logic                         clock,
   input  wire  logic                         reset,
   input  wire  logic                         req_tvalid,
   output logic                               req_tready,
   input  wire  logic [clba_pkg::DATA_W-1:0]  cell_density,
   input  wire  logic [clba_pkg::DATA_W-1:0]  prev_cell,
   input  wire  clba_pkg::item_ctl_type       item_ctl,
   input  wire  clba_pkg::mem_rsp_type        mem_rsp,
   output logic                               rsp_tvalid,
   input  wire  logic                         rsp_tready,
   output logic [clba_pkg::DATA_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast
);
   import clba_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   item_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic [DATA_W-1:0]  s1_cur_ff, s1_cur_in;
   logic [DATA_W-1:0]  s1_prev_ff, s1_prev_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [SUM4_W-1:0]  s2_cur_sum_ff, s2_cur_sum_in;
   logic [SUM4_W-1:0]  s2_old_sum_ff, s2_old_sum_in;
   logic [SHIFT_W-1:0] s2_shift_ff, s2_shift_in;
   logic               s2_last_ff, s2_last_in;

   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   logic               out_en, s2_en, s1_en, accept;
   logic [SUM4_W-1:0]  cur_sum, old_sum;
   logic [SUM8_W-1:0]  total, shifted;

   always_comb begin
      out_en = !out_valid_ff | rsp_tready;
      s2_en  = !s2_valid_ff | out_en;
      s1_en  = !s1_valid_ff | s2_en;
      accept = req_tvalid & s1_en;
   end

   assign req_tready = s1_en;

   always_comb begin
      cur_sum = '0;
      old_sum = '0;
      if (s1_ctl_ff.vz1) begin
         cur_sum = (s1_ctl_ff.vy1 & s1_ctl_ff.vx1 ? SUM4_W'(s1_cur_ff) : '0)
                 + (s1_ctl_ff.vy1 & s1_ctl_ff.vx0 ? SUM4_W'(s1_prev_ff) : '0)
                 + (s1_ctl_ff.vy0 & s1_ctl_ff.vx1 ? SUM4_W'(mem_rsp.row_here) : '0)
                 + (s1_ctl_ff.vy0 & s1_ctl_ff.vx0 ? SUM4_W'(mem_rsp.row_left) : '0);
      end
      if (s1_ctl_ff.vz0) begin
         old_sum = (s1_ctl_ff.vy1 & s1_ctl_ff.vx1 ? SUM4_W'(mem_rsp.pp_here) : '0)
                 + (s1_ctl_ff.vy1 & s1_ctl_ff.vx0 ? SUM4_W'(mem_rsp.pp_left) : '0)
                 + (s1_ctl_ff.vy0 & s1_ctl_ff.vx1 ? SUM4_W'(mem_rsp.pp_here_up) : '0)
                 + (s1_ctl_ff.vy0 & s1_ctl_ff.vx0 ? SUM4_W'(mem_rsp.pp_left_up) : '0);
      end
      total   = SUM8_W'(s2_cur_sum_ff) + SUM8_W'(s2_old_sum_ff);
      shifted = total >> s2_shift_ff;
   end

   always_comb begin
      s1_valid_in = s1_en ? req_tvalid : s1_valid_ff;
      s1_ctl_in   = accept ? item_ctl : s1_ctl_ff;
      s1_cur_in   = accept ? cell_density : s1_cur_ff;
      s1_prev_in  = accept ? prev_cell : s1_prev_ff;

      s2_valid_in   = s2_en ? s1_valid_ff : s2_valid_ff;
      s2_cur_sum_in = s2_cur_sum_ff;
      s2_old_sum_in = s2_old_sum_ff;
      s2_shift_in   = s2_shift_ff;
      s2_last_in    = s2_last_ff;
      if (s2_en && s1_valid_ff) begin
         s2_cur_sum_in = cur_sum;
         s2_old_sum_in = old_sum;
         s2_shift_in   = s1_ctl_ff.shift;
         s2_last_in    = s1_ctl_ff.last;
      end

      out_valid_in = out_en ? s2_valid_ff : out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (out_en && s2_valid_ff) begin
         out_data_in = shifted[DATA_W-1:0];
         out_last_in = s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff     <= s1_ctl_in;
      s1_cur_ff     <= s1_cur_in;
      s1_prev_ff    <= s1_prev_in;
      s2_cur_sum_ff <= s2_cur_sum_in;
      s2_old_sum_ff <= s2_old_sum_in;
      s2_shift_ff   <= s2_shift_in;
      s2_last_ff    <= s2_last_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== verif/box_average_board_pkg.sv =====
// Scoreboard for the cell-to-lattice box average: predicts each lattice sample and checks it.
package box_average_board_pkg;

   import clba_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] density;
      logic              last;
   } lattice_sample_type;

   class box_average_board_type;
      logic [DIM_W-1:0]  dim_x;
      logic [DIM_W-1:0]  dim_y;
      logic [DIM_W-1:0]  dim_z;
      int                pos_x;
      int                pos_y;
      int                pos_z;
      logic [DATA_W-1:0] prev_cell;
      logic [DATA_W-1:0] row_store [LINE_LEN];
      logic [DATA_W-1:0] plane_store [LINE_LEN * LINE_LEN];
      lattice_sample_type due_samples [$];
      int                mismatches;

      function new();
         dim_x = DIM_RESET;
         dim_y = DIM_RESET;
         dim_z = DIM_RESET;
         pos_x = 0;
         pos_y = 0;
         pos_z = 0;
         prev_cell = '0;
         foreach (row_store[i]) row_store[i] = '0;
         foreach (plane_store[i]) plane_store[i] = '0;
         mismatches = 0;
      endfunction

      function int span(input logic [DIM_W-1:0] d);
         return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
      endfunction

      function void set_dim(input logic [CSR_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
         case (index)
            REG_DIM_X: dim_x = value;
            REG_DIM_Y: dim_y = value;
            REG_DIM_Z: dim_z = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_samples.size();
      endfunction

      // Beats still needed to reach the final lattice point of the current volume.
      function int cells_left();
         int dx, dy, dz, x, y, z;
         dx = span(dim_x);
         dy = span(dim_y);
         dz = span(dim_z);
         x = (pos_x > dx) ? 0 : pos_x;
         y = (pos_y > dy) ? 0 : pos_y;
         z = (pos_z > dz) ? 0 : pos_z;
         return (dz - z) * (dy + 1) * (dx + 1) + (dy - y) * (dx + 1) + (dx - x) + 1;
      endfunction

      function void note_cell(input logic [DATA_W-1:0] cell_density);
         int dx, dy, dz, x, y, z, shift;
         int unsigned total;
         logic vx0, vx1, vy0, vy1, vz0, vz1;
         logic [DATA_W-1:0] row_left, row_here;
         lattice_sample_type sample;
         dx = span(dim_x);
         dy = span(dim_y);
         dz = span(dim_z);
         if (pos_x > dx) pos_x = 0;
         if (pos_y > dy) pos_y = 0;
         if (pos_z > dz) pos_z = 0;
         x = pos_x;
         y = pos_y;
         z = pos_z;
         vx0 = (x >= 1) && (x - 1 < dx);
         vx1 = x < dx;
         vy0 = (y >= 1) && (y - 1 < dy);
         vy1 = y < dy;
         vz0 = (z >= 1) && (z - 1 < dz);
         vz1 = z < dz;
         row_left = (x >= 1) ? row_store[x - 1] : '0;
         row_here = row_store[x];
         total = 0;
         if (vz1) begin
            if (vy1 && vx1) total += cell_density;
            if (vy1 && vx0) total += prev_cell;
            if (vy0 && vx1) total += row_here;
            if (vy0 && vx0) total += row_left;
         end
         if (vz0) begin
            if (vy1 && vx1) total += plane_store[x + LINE_LEN * y];
            if (vy1 && vx0) total += plane_store[(x - 1) + LINE_LEN * y];
            if (vy0 && vx1) total += plane_store[x + LINE_LEN * (y - 1)];
            if (vy0 && vx0) total += plane_store[(x - 1) + LINE_LEN * (y - 1)];
         end
         shift = int'(vx0 && vx1) + int'(vy0 && vy1) + int'(vz0 && vz1);

         // Each store entry is replaced only after its last reader has used it.
         if (x >= 1 && y >= 1) plane_store[(x - 1) + LINE_LEN * (y - 1)] = row_left;
         if (x >= 1) row_store[x - 1] = prev_cell;
         prev_cell = cell_density;

         sample.density = DATA_W'(total >> shift);
         sample.last = (x == dx) && (y == dy) && (z == dz);
         due_samples.push_back(sample);

         if (x >= dx) begin
            pos_x = 0;
            if (y >= dy) begin
               pos_y = 0;
               pos_z = (z >= dz) ? 0 : z + 1;
            end else begin
               pos_y = y + 1;
            end
         end else begin
            pos_x = x + 1;
         end
      endfunction

      function void check_sample(input logic [DATA_W-1:0] density, input logic last);
         lattice_sample_type want;
         if (due_samples.size() == 0) begin
            $display("%0t: sample with none expected: density %h last %b", $time, density, last);
            mismatches++;
            return;
         end
         want = due_samples.pop_front();
         if (want.density !== density) begin
            $display("%0t: sample_density expected %h actual %h", $time, want.density, density);
            mismatches++;
         end
         if (want.last !== last) begin
            $display("%0t: last_sample expected %b actual %b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== verif/cell_to_lattice_box_average_core_test.sv =====
// Testbench top for the cell-to-lattice box average core: stimulus, handshakes and final verdict.
module cell_to_lattice_box_average_core_test;

   import clba_pkg::*;
   import box_average_board_pkg::*;

   localparam int RUN_LIMIT = 1_600_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   bit gaps_on = 1'b1;
   box_average_board_type board;

   cell_to_lattice_box_average_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !gaps_on || $urandom_range(0, 99) >= 33;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_sample(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_cell(input logic [DATA_W-1:0] cell_density);
      while (gaps_on && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cell_density;
      do @(posedge clock); while (!req_tready);
      board.note_cell(cell_density);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_dim(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                           input logic [DIM_W-1:0] z);
      write_reg(REG_DIM_X, x);
      write_reg(REG_DIM_Y, y);
      write_reg(REG_DIM_Z, z);
   endtask

   function automatic logic [DATA_W-1:0] random_cell();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   initial begin
      int random_cells;
      int vol;
      logic [DIM_W-1:0] vol_dims [3];
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset dimensions give a single cell in a 2x2x2 lattice; the eight beats are its eight points.
      send_cell(16'h8001);
      repeat (7) send_cell(16'hFFFF);
      wait_idle();

      // All dimensions zero: one lattice point with no cell around it.
      set_dims(DIM_W'(0), DIM_W'(0), DIM_W'(0));
      send_cell(16'hFFFF);
      wait_idle();

      // Narrow dim_x in the middle of the second plane, so the position wraps back to zero.
      set_dims(DIM_W'(2), DIM_W'(1), DIM_W'(1));
      send_cell(16'hFFFF);
      send_cell(16'h0000);
      repeat (6) send_cell(16'hFFFF);
      wait_idle();
      write_reg(REG_DIM_X, DIM_W'(1));
      repeat (board.cells_left()) send_cell(random_cell());
      wait_idle();

      random_cells = 0;
      vol = 0;
      while (random_cells < 550) begin
         if (vol >= 1 && vol <= 3) begin
            foreach (vol_dims[i]) vol_dims[i] = DIM_W'($urandom_range(0, 1));
            vol_dims[vol - 1] = DIM_W'(MAX_DIM);
         end else if (vol == 4) begin
            vol_dims[0] = DIM_W'(3);
            vol_dims[1] = DIM_W'(4);
            vol_dims[2] = DIM_W'(2);
         end else if ($urandom_range(0, 5) == 0) begin
            foreach (vol_dims[i]) vol_dims[i] = DIM_W'($urandom_range(1, 4));
            vol_dims[$urandom_range(0, 2)] = DIM_W'(0);
         end else begin
            foreach (vol_dims[i]) vol_dims[i] = DIM_W'($urandom_range(1, 5));
         end
         gaps_on = (vol != 4);
         set_dims(vol_dims[0], vol_dims[1], vol_dims[2]);
         random_cells += board.cells_left();
         repeat (board.cells_left()) send_cell(random_cell());
         wait_idle();
         vol++;
      end

      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/clba_pkg.sv
rtl/core/clba_seq.sv
rtl/core/clba_store.sv
rtl/core/clba_avg.sv
rtl/core/cell_to_lattice_box_average_core.sv
verif/box_average_board_pkg.sv
verif/cell_to_lattice_box_average_core_test.sv
